FILE: sv/ter_pkg.sv
// ter_pkg: constants, types and codes for the triangle edge rasteriser
// used by triangle_edge_rasteriser; no dependencies
package ter_pkg;

  // screen and fixed-point format
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 4;

  // field widths
  localparam int COORD_W  = 16;
  localparam int DIM_W    = 9;
  localparam int COLOUR_W = 32;
  localparam int COUNT_W  = 17;
  localparam int RC_W     = 8;

  // effective screen limits in register range
  localparam int DIM_MAX   = (1 << DIM_W) - 1;
  localparam int MAX_W_SAT = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int MAX_H_SAT = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;

  // framebuffer
  localparam int FB_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int FB_ADDR_W = $clog2(FB_DEPTH);

  // edge arithmetic
  localparam int HX_W    = DIM_W + FRAC_BITS;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MUL_A_W = DIFF_W;
  localparam int MUL_B_W = ((HX_W + 1 > COORD_W) ? HX_W + 1 : COORD_W) + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int EDGE_W  = PROD_W + 1;

  // stream and register port
  localparam int IN_DATA_W  = 6 * COORD_W + COLOUR_W + 2 * RC_W;
  localparam int OUT_FLD_W  = COLOUR_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // request kinds
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_BOX   = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_WALK  = 9'b000010000,
    ST_RADDR = 9'b000100000,
    ST_RMEM  = 9'b001000000,
    ST_RDATA = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

endpackage

FILE: sv/triangle_edge_rasteriser.sv
// triangle_edge_rasteriser: edge-function triangle fill into an on-chip framebuffer
// depends on ter_pkg
//
// sequence: a read request passes ST_RADDR, ST_RMEM, ST_RDATA and ST_DONE; a draw request
// passes ST_BOX, the ST_MUL setup steps, the walk over its clamped box unless empty, ST_DONE
// throughput: one request at a time; the pixel walk visits one pixel a cycle, and the
// single shared multiplier builds the edge start values and row address before the walk
// reset: synchronous, active high; afterwards a clearing pass writes zero to all
// MAX_WIDTH*MAX_HEIGHT framebuffer words before the first request is taken
module triangle_edge_rasteriser (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ter_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ter_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ter_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // ax_coord, ay_coord, bx_coord, by_coord, cx_coord, cy_coord, fill_colour, read_x, read_y
  input  logic [ter_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                s_tlast,   // last_triangle
  input  logic                                s_tuser,   // opcode
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // read_colour, pixels_written, zero fill
  output logic [ter_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tlast    // batch_end
);

  localparam int CW = ter_pkg::COORD_W;
  localparam int EW = ter_pkg::EDGE_W;
  localparam int DW = ter_pkg::DIM_W;
  localparam int AW = ter_pkg::FB_ADDR_W;
  localparam int FB = ter_pkg::FRAC_BITS;
  localparam int HW = ter_pkg::HX_W;

  // sign-extend a coordinate to the edge difference width
  function automatic logic signed [ter_pkg::DIFF_W-1:0] sx_diff(
    input logic signed [ter_pkg::COORD_W-1:0] v);
    sx_diff = {v[CW-1], v};
  endfunction

  function automatic logic signed [ter_pkg::COORD_W-1:0] min3(
    input logic signed [ter_pkg::COORD_W-1:0] a,
    input logic signed [ter_pkg::COORD_W-1:0] b,
    input logic signed [ter_pkg::COORD_W-1:0] c);
    logic signed [ter_pkg::COORD_W-1:0] m;
    m    = (a < b) ? a : b;
    min3 = (m < c) ? m : c;
  endfunction

  function automatic logic signed [ter_pkg::COORD_W-1:0] max3(
    input logic signed [ter_pkg::COORD_W-1:0] a,
    input logic signed [ter_pkg::COORD_W-1:0] b,
    input logic signed [ter_pkg::COORD_W-1:0] c);
    logic signed [ter_pkg::COORD_W-1:0] m;
    m    = (a > b) ? a : b;
    max3 = (m > c) ? m : c;
  endfunction

  // clamp a coordinate into [0, hi]
  function automatic logic [ter_pkg::HX_W-1:0] clamp_hi(
    input logic signed [ter_pkg::COORD_W-1:0] v,
    input logic        [ter_pkg::HX_W-1:0]    hi);
    logic signed [ter_pkg::HX_W:0] his;
    his = $signed({1'b0, hi});
    if (v < 0) begin
      clamp_hi = '0;
    end else if (v > his) begin
      clamp_hi = hi;
    end else begin
      clamp_hi = v[HW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0] width_cfg;
  logic [DW-1:0] height_cfg;
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= DW'(256);
      height_cfg <= DW'(256);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ter_pkg::REG_WIDTH:  width_cfg  <= pwdata[DW-1:0];
        ter_pkg::REG_HEIGHT: height_cfg <= pwdata[DW-1:0];
        default:             width_cfg  <= width_cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ter_pkg::REG_HEIGHT: prdata = ter_pkg::APB_DATA_W'(height_cfg);
      default:             prdata = ter_pkg::APB_DATA_W'(width_cfg);
    endcase
  end

  // oversized registers saturate to the framebuffer size
  assign w_eff = (width_cfg  > DW'(ter_pkg::MAX_W_SAT)) ? DW'(ter_pkg::MAX_W_SAT)
                                                        : width_cfg;
  assign h_eff = (height_cfg > DW'(ter_pkg::MAX_H_SAT)) ? DW'(ter_pkg::MAX_H_SAT)
                                                        : height_cfg;

  // ---------------------------------------------------------------------------
  // request fields
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]                    vx [3];
  logic signed [CW-1:0]                    vy [3];
  logic [ter_pkg::COLOUR_W-1:0]            colour;
  logic [ter_pkg::RC_W-1:0]                rd_x;
  logic [ter_pkg::RC_W-1:0]                rd_y;
  logic                                    last_r;
  logic                                    op_r;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  ter_pkg::state_t state;
  ter_pkg::state_t state_next;

  logic [AW-1:0] clr_addr;
  logic [2:0]    step;          // multiplier step inside ST_MUL
  logic          box_empty;
  logic          row_end;
  logic          box_end;
  logic          covered;
  logic          out_free;
  logic          s_acc;

  // bounding box, in pixels; x1 and y1 exclusive
  logic [DW-1:0] x0, x1, y0, y1;
  logic [DW-1:0] px, py;        // pixel under test
  logic [AW-1:0] row_base;      // framebuffer address of (0, py)

  // edge values: current pixel and row start, differences per edge
  logic signed [ter_pkg::DIFF_W-1:0] dx_e [3];
  logic signed [ter_pkg::DIFF_W-1:0] dy_e [3];
  logic signed [EW-1:0]              e_cur [3];
  logic signed [EW-1:0]              e_row [3];
  logic signed [EW-1:0]              acc;

  logic [ter_pkg::COUNT_W-1:0]  count;
  logic [ter_pkg::COLOUR_W-1:0] res_colour;
  logic                         rd_off;

  assign s_tready = (state == ter_pkg::ST_IDLE);
  assign s_acc    = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign row_end  = (px == x1 - DW'(1));
  assign box_end  = row_end & (py == y1 - DW'(1));

  // pixel passes when every edge value is zero or negative
  always_comb begin
    covered = 1'b1;
    for (int k = 0; k < 3; k++) begin
      covered = covered & (e_cur[k][EW-1] | (e_cur[k] == '0));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ter_pkg::ST_CLEAR: if (clr_addr == '1) state_next = ter_pkg::ST_IDLE;
      ter_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_next = (s_tuser == ter_pkg::OP_READ) ? ter_pkg::ST_RADDR : ter_pkg::ST_BOX;
        end
      end
      ter_pkg::ST_BOX:   state_next = ter_pkg::ST_MUL;
      // an empty box skips the walk after the multiply sequence
      ter_pkg::ST_MUL: begin
        if (step == 3'd7) state_next = box_empty ? ter_pkg::ST_DONE : ter_pkg::ST_WALK;
      end
      ter_pkg::ST_WALK:  if (box_end) state_next = ter_pkg::ST_DONE;
      ter_pkg::ST_RADDR: state_next = ter_pkg::ST_RMEM;
      ter_pkg::ST_RMEM:  state_next = ter_pkg::ST_RDATA;
      ter_pkg::ST_RDATA: state_next = ter_pkg::ST_DONE;
      ter_pkg::ST_DONE:  if (out_free) state_next = ter_pkg::ST_IDLE;
      default:           state_next = ter_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ter_pkg::ST_CLEAR;
      clr_addr <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ter_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      step <= (state == ter_pkg::ST_MUL) ? step + 3'd1 : 3'd0;
      if (state == ter_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // bounding box, clamped to the screen in fixed point
  // ---------------------------------------------------------------------------
  logic [HW-1:0] hx, hy;
  logic [HW-1:0] cminx, cmaxx, cminy, cmaxy;
  logic [HW:0]   ceilx, ceily;
  logic [DW-1:0] bx0, bx1, by0, by1;

  assign hx    = {w_eff, FB'(0)};
  assign hy    = {h_eff, FB'(0)};
  assign cminx = clamp_hi(min3(vx[0], vx[1], vx[2]), hx);
  assign cmaxx = clamp_hi(max3(vx[0], vx[1], vx[2]), hx);
  assign cminy = clamp_hi(min3(vy[0], vy[1], vy[2]), hy);
  assign cmaxy = clamp_hi(max3(vy[0], vy[1], vy[2]), hy);
  assign ceilx = {1'b0, cmaxx} + (HW+1)'((1 << FB) - 1);
  assign ceily = {1'b0, cmaxy} + (HW+1)'((1 << FB) - 1);
  assign bx0   = cminx[HW-1:FB];
  assign by0   = cminy[HW-1:FB];
  assign bx1   = DW'(ceilx >> FB);
  assign by1   = DW'(ceily >> FB);

  // ---------------------------------------------------------------------------
  // shared multiplier
  // steps 0..5: edge k = step/2, even step dx*(ty0-vy[k]), odd step dy*(tx0-vx[k])
  // step 6: row base y0*width; read requests use the multiplier for read_y*width, the pixel address
  // ---------------------------------------------------------------------------
  logic signed [ter_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ter_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ter_pkg::PROD_W-1:0]  prod_q;
  logic signed [ter_pkg::MUL_B_W-1:0] tx0, ty0;
  logic [1:0]                         mk;
  logic [2:0]                         prev;
  logic [1:0]                         pk;

  assign tx0  = $signed(ter_pkg::MUL_B_W'({x0, FB'(0)}));
  assign ty0  = $signed(ter_pkg::MUL_B_W'({y0, FB'(0)}));
  assign mk   = step[2:1];
  assign prev = step - 3'd1;
  assign pk   = prev[2:1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ter_pkg::ST_MUL) begin
      if (step == 3'd6) begin
        mul_a = $signed(ter_pkg::MUL_A_W'(y0));
        mul_b = $signed(ter_pkg::MUL_B_W'(w_eff));
      end else if (step < 3'd6) begin
        if (!step[0]) begin
          mul_a = dx_e[mk];
          mul_b = ty0 - ter_pkg::MUL_B_W'(vy[mk]);
        end else begin
          mul_a = dy_e[mk];
          mul_b = tx0 - ter_pkg::MUL_B_W'(vx[mk]);
        end
      end
    end else if (state == ter_pkg::ST_RADDR) begin
      mul_a = $signed(ter_pkg::MUL_A_W'(rd_y));
      mul_b = $signed(ter_pkg::MUL_B_W'(w_eff));
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // framebuffer: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [ter_pkg::COLOUR_W-1:0] fb_mem [ter_pkg::FB_DEPTH];
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [ter_pkg::COLOUR_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [ter_pkg::COLOUR_W-1:0] rd_data;

  assign mem_we    = (state == ter_pkg::ST_CLEAR) | ((state == ter_pkg::ST_WALK) & covered);
  assign mem_waddr = (state == ter_pkg::ST_CLEAR) ? clr_addr : row_base + AW'(px);
  assign mem_wdata = (state == ter_pkg::ST_CLEAR) ? '0 : colour;
  assign mem_raddr = prod_q[AW-1:0] + AW'(rd_x);

  always_ff @(posedge clk) begin
    if (mem_we) fb_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rd_data <= fb_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_acc) begin
      op_r   <= s_tuser;
      last_r <= s_tlast;
      for (int k = 0; k < 3; k++) begin
        vx[k] <= s_tdata[2*k*CW +: CW];
        vy[k] <= s_tdata[(2*k+1)*CW +: CW];
      end
      colour <= s_tdata[6*CW +: ter_pkg::COLOUR_W];
      rd_x   <= s_tdata[6*CW + ter_pkg::COLOUR_W +: ter_pkg::RC_W];
      rd_y   <= s_tdata[6*CW + ter_pkg::COLOUR_W + ter_pkg::RC_W +: ter_pkg::RC_W];
      count  <= '0;
    end

    if (state == ter_pkg::ST_BOX) begin
      x0        <= bx0;
      x1        <= bx1;
      y0        <= by0;
      y1        <= by1;
      px        <= bx0;
      py        <= by0;
      box_empty <= (bx0 == bx1) | (by0 == by1);
      // edges a->b, b->c, c->a
      for (int k = 0; k < 3; k++) begin
        dx_e[k] <= sx_diff(vx[(k+1)%3]) - sx_diff(vx[k]);
        dy_e[k] <= sx_diff(vy[(k+1)%3]) - sx_diff(vy[k]);
      end
    end

    // accumulate the product issued in the previous step
    if (state == ter_pkg::ST_MUL && step != 3'd0) begin
      if (prev == 3'd6) begin
        row_base <= prod_q[AW-1:0];
      end else if (!prev[0]) begin
        acc <= EW'(prod_q);
      end else begin
        e_cur[pk] <= acc - EW'(prod_q);
        e_row[pk] <= acc - EW'(prod_q);
      end
    end

    if (state == ter_pkg::ST_WALK) begin
      if (covered && count != '1) count <= count + ter_pkg::COUNT_W'(1);
      if (row_end) begin
        // next row: step every edge by dx, restart the column
        px       <= x0;
        py       <= py + DW'(1);
        row_base <= row_base + AW'(w_eff);
        for (int k = 0; k < 3; k++) begin
          e_row[k] <= e_row[k] + (EW'(dx_e[k]) <<< FB);
          e_cur[k] <= e_row[k] + (EW'(dx_e[k]) <<< FB);
        end
      end else begin
        // next column: every edge falls by dy
        px <= px + DW'(1);
        for (int k = 0; k < 3; k++) begin
          e_cur[k] <= e_cur[k] - (EW'(dy_e[k]) <<< FB);
        end
      end
    end

    if (state == ter_pkg::ST_RADDR) begin
      rd_off <= ~((DW'(rd_x) < w_eff) & (DW'(rd_y) < h_eff));
    end

    if (state == ter_pkg::ST_RDATA) begin
      res_colour <= rd_off ? '0 : rd_data;
    end

    // result register: held until the sink takes it
    if (state == ter_pkg::ST_DONE && out_free) begin
      m_tdata <= ter_pkg::OUT_DATA_W'({
                   (op_r == ter_pkg::OP_READ) ? ter_pkg::COUNT_W'(0) : count,
                   (op_r == ter_pkg::OP_READ) ? res_colour : ter_pkg::COLOUR_W'(0)});
      m_tlast <= (op_r == ter_pkg::OP_DRAW) & last_r;
    end
  end

endmodule

FILE: verif/tb_triangle_edge_rasteriser.sv
`timescale 1ns / 100ps
// tb_triangle_edge_rasteriser: self-checking bench for the triangle edge rasteriser
// mirrors the framebuffer and pixel walk to predict fill counts and pixel reads
// depends on ter_pkg and triangle_edge_rasteriser
module tb_triangle_edge_rasteriser;

  localparam int FRAC_BITS  = ter_pkg::FRAC_BITS;
  localparam int COUNT_W    = ter_pkg::COUNT_W;
  localparam int COORD_W    = ter_pkg::COORD_W;
  localparam int COLOUR_W   = ter_pkg::COLOUR_W;
  localparam int RC_W       = ter_pkg::RC_W;
  localparam int DIM_W      = ter_pkg::DIM_W;
  localparam int FB_DEPTH   = ter_pkg::FB_DEPTH;
  localparam int MAX_WIDTH  = ter_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = ter_pkg::MAX_HEIGHT;
  localparam int APB_ADDR_W = ter_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = ter_pkg::APB_DATA_W;
  localparam int IN_DATA_W  = ter_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = ter_pkg::OUT_DATA_W;

  localparam int ONE_PX    = 1 << FRAC_BITS;
  localparam int COUNT_CAP = (1 << COUNT_W) - 1;

  // one request as it travels on the slave side
  typedef struct {
    bit                op;
    bit [COORD_W-1:0]  ax, ay, bx, by, cx, cy;
    bit [COLOUR_W-1:0] colour;
    bit [RC_W-1:0]     rx, ry;
    bit                last;
  } raster_req_t;

  // one result as it should come back on the master side
  typedef struct {
    bit [COLOUR_W-1:0] colour;
    bit [COUNT_W-1:0]  count;
    bit                batch_end;
  } raster_outcome_t;

  // shadow of the framebuffer and screen registers; predicts each result on acceptance
  class framebuffer_shadow;
    bit [COLOUR_W-1:0] framebuffer [FB_DEPTH];
    bit [DIM_W-1:0]    width_reg;
    bit [DIM_W-1:0]    height_reg;
    raster_outcome_t   pending_outcomes [$];
    int                failures;
    int                draws;
    int                reads;
    longint            pixels;

    function new();
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      failures   = 0;
      draws      = 0;
      reads      = 0;
      pixels     = 0;
    endfunction

    function void set_register(bit idx, bit [DIM_W-1:0] value);
      if (idx == ter_pkg::REG_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    // registers above the framebuffer size saturate
    function int active_width();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function int active_height();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function longint min3(longint a, longint b, longint c);
      longint m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
    endfunction

    function longint max3(longint a, longint b, longint c);
      longint m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
    endfunction

    function longint clamp_to(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // (q-p) x (t-p) <= 0
    function bit right_of_line(longint px, longint py, longint qx, longint qy,
                               longint tx, longint ty);
      return ((qx - px) * (ty - py) - (qy - py) * (tx - px)) <= 0;
    endfunction

    function bit [COUNT_W-1:0] fill_triangle(raster_req_t req);
      longint ax, ay, bx, by, cx, cy;
      longint x0, x1, y0, y1, x, y, px, py;
      int     w, h;
      int     covered;
      w  = active_width();
      h  = active_height();
      ax = longint'($signed(req.ax));
      ay = longint'($signed(req.ay));
      bx = longint'($signed(req.bx));
      by = longint'($signed(req.by));
      cx = longint'($signed(req.cx));
      cy = longint'($signed(req.cy));
      // floor at the low corner, ceil at the high corner, both clamped to the screen
      x0 = clamp_to(min3(ax, bx, cx), longint'(w) * ONE_PX) / ONE_PX;
      x1 = (clamp_to(max3(ax, bx, cx), longint'(w) * ONE_PX) + ONE_PX - 1) / ONE_PX;
      y0 = clamp_to(min3(ay, by, cy), longint'(h) * ONE_PX) / ONE_PX;
      y1 = (clamp_to(max3(ay, by, cy), longint'(h) * ONE_PX) + ONE_PX - 1) / ONE_PX;
      covered = 0;
      for (y = y0; y < y1; y++) begin
        for (x = x0; x < x1; x++) begin
          px = x * ONE_PX;
          py = y * ONE_PX;
          if (right_of_line(ax, ay, bx, by, px, py) && right_of_line(bx, by, cx, cy, px, py) &&
              right_of_line(cx, cy, ax, ay, px, py)) begin
            framebuffer[y * w + x] = req.colour;
            if (covered < COUNT_CAP) covered++;
          end
        end
      end
      return COUNT_W'(covered);
    endfunction

    function bit [COLOUR_W-1:0] fetch_pixel(bit [RC_W-1:0] x, bit [RC_W-1:0] y);
      if (int'(x) < active_width() && int'(y) < active_height())
        return framebuffer[int'(y) * active_width() + int'(x)];
      return '0;
    endfunction

    function void note_request(raster_req_t req);
      raster_outcome_t due;
      due.colour    = '0;
      due.count     = '0;
      due.batch_end = 1'b0;
      if (req.op == ter_pkg::OP_READ) begin
        due.colour = fetch_pixel(req.rx, req.ry);
        reads++;
      end else begin
        due.count     = fill_triangle(req);
        due.batch_end = req.last;
        pixels += due.count;
        draws++;
      end
      pending_outcomes.push_back(due);
    endfunction

    function void check_result(logic [COLOUR_W-1:0] colour, logic [COUNT_W-1:0] count,
                               logic batch_end);
      raster_outcome_t due;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request pending: read_colour %h pixels_written %0d",
               colour, count);
        failures++;
        return;
      end
      due = pending_outcomes.pop_front();
      if (colour !== due.colour) begin
        $error("read_colour: expected %h, got %h", due.colour, colour);
        failures++;
      end
      if (count !== due.count) begin
        $error("pixels_written: expected %0d, got %0d", due.count, count);
        failures++;
      end
      if (batch_end !== due.batch_end) begin
        $error("batch_end: expected %0b, got %0b", due.batch_end, batch_end);
        failures++;
      end
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // ax, ay, bx, by, cx, cy, fill_colour, read_x, read_y from bit 0 up
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // read_colour, pixels_written, zero fill from bit 0 up
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  framebuffer_shadow shadow = new();

  bit steady = 1'b0;        // set for a stretch with no idling on either side
  int pos_x  = 0;           // pixel near the latest random draw, where reads aim
  int pos_y  = 0;
  int screens_tried = 1;

  triangle_edge_rasteriser dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls about a third of the time outside the steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.check_result(m_tdata[COLOUR_W-1:0], m_tdata[COLOUR_W +: COUNT_W], m_tlast);
  end

  // vertex coordinates are in pixels times ONE_PX; read fields carry noise
  function automatic raster_req_t draw_req(int ax, int ay, int bx, int by, int cx, int cy,
                                           bit [COLOUR_W-1:0] colour, bit last);
    raster_req_t r;
    r.op     = ter_pkg::OP_DRAW;
    r.ax     = COORD_W'(ax);
    r.ay     = COORD_W'(ay);
    r.bx     = COORD_W'(bx);
    r.by     = COORD_W'(by);
    r.cx     = COORD_W'(cx);
    r.cy     = COORD_W'(cy);
    r.colour = colour;
    r.rx     = RC_W'($urandom);
    r.ry     = RC_W'($urandom);
    r.last   = last;
    return r;
  endfunction

  // vertex, colour and batch fields carry noise on a read
  function automatic raster_req_t read_req(int x, int y);
    raster_req_t r;
    r.op     = ter_pkg::OP_READ;
    r.ax     = COORD_W'($urandom);
    r.ay     = COORD_W'($urandom);
    r.bx     = COORD_W'($urandom);
    r.by     = COORD_W'($urandom);
    r.cx     = COORD_W'($urandom);
    r.cy     = COORD_W'($urandom);
    r.colour = $urandom;
    r.rx     = RC_W'(x);
    r.ry     = RC_W'(y);
    r.last   = 1'($urandom);
    return r;
  endfunction

  // random offset within +-span pixels, at sub-pixel resolution
  function automatic int jitter(int span);
    int spread;
    spread = $urandom_range(0, 2 * span * ONE_PX);
    return spread - span * ONE_PX;
  endfunction

  // present one request, with random idle cycles ahead of it outside the steady stretch, and wait for acceptance
  task automatic send_request(raster_req_t r);
    if (!steady) begin
      while ($urandom_range(0, 99) < 35) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.ry, r.rx, r.colour, r.cy, r.cx, r.by, r.bx, r.ay, r.ax};
    s_tlast  <= r.last;
    s_tuser  <= r.op;
    do @(posedge clk); while (!s_tready);
    shadow.note_request(r);
  endtask

  // hold off the sender until every result is back, then let the block go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (shadow.pending_outcomes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // setup cycle, then access cycle; the register takes the value at the access edge
  task automatic write_register(bit idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << 2;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.set_register(idx, DIM_W'(value));
  endtask

  task automatic apply_screen(int w, int h);
    settle();
    write_register(ter_pkg::REG_WIDTH, w);
    write_register(ter_pkg::REG_HEIGHT, h);
    screens_tried++;
  endtask

  // wound triangles with small boxes, reads mostly aimed at the latest one, some noise
  task automatic run_random_phase(int w, int h, bit calm, int n);
    raster_req_t      r;
    int               i, kind, span, bx0, by0, ew, eh;
    longint           turn;
    bit [COORD_W-1:0] keep_x, keep_y;
    apply_screen(w, h);
    steady = calm;
    ew = shadow.active_width();
    eh = shadow.active_height();
    for (i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // every field random; a random draw box spans the screen, so only on small ones
        r = read_req($urandom, $urandom);
        r.op = 1'($urandom);
        if (r.op == ter_pkg::OP_DRAW && ew * eh > 4096) r.op = ter_pkg::OP_READ;
      end else if (kind < 50) begin
        if ($urandom_range(0, 99) < 60) begin
          r = read_req(pos_x + jitter(12) / ONE_PX, pos_y + jitter(12) / ONE_PX);
        end else begin
          r = read_req($urandom, $urandom);
        end
      end else begin
        span = $urandom_range(0, 20);
        bx0  = $urandom_range(0, ew + 16);
        by0  = $urandom_range(0, eh + 16);
        bx0  = bx0 - 8;
        by0  = by0 - 8;
        r = draw_req(bx0 * ONE_PX + jitter(span), by0 * ONE_PX + jitter(span),
                     bx0 * ONE_PX + jitter(span), by0 * ONE_PX + jitter(span),
                     bx0 * ONE_PX + jitter(span), by0 * ONE_PX + jitter(span),
                     $urandom, 1'($urandom));
        // most triangles get the winding that actually covers pixels
        turn = (longint'($signed(r.bx)) - $signed(r.ax)) * (longint'($signed(r.cy)) - $signed(r.ay))
             - (longint'($signed(r.by)) - $signed(r.ay)) * (longint'($signed(r.cx)) - $signed(r.ax));
        if (turn > 0 && $urandom_range(0, 99) < 85) begin
          keep_x = r.bx;
          keep_y = r.by;
          r.bx   = r.cx;
          r.by   = r.cy;
          r.cx   = keep_x;
          r.cy   = keep_y;
        end
        pos_x = bx0;
        pos_y = by0;
      end
      // once per idling phase the sender waits for the block to drain completely
      if (i == n / 2 && !calm) settle();
      send_request(r);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // full screen after reset; the clearing pass must leave zeros behind
    send_request(read_req(0, 0));
    // extreme vertices: the box clamps to the whole screen, but no pixel lies inside the triangle
    send_request(draw_req(-32768, -32768, -32768, 32767, 32767, -32768, 32'ha5a5_5a5a, 1'b0));
    send_request(read_req(0, 255));
    send_request(read_req(255, 0));
    // plain triangle with fractional vertices, then the same with opposite winding
    send_request(draw_req(40, 36, 132, 300, 330, 70, 32'hffff_ffff, 1'b0));
    send_request(draw_req(40, 36, 330, 70, 132, 300, 32'h0000_0000, 1'b1));
    // collinear vertices: only pixels on the line pass
    send_request(draw_req(32, 32, 160, 160, 96, 96, 32'h1234_5678, 1'b1));
    // coincident vertices on a pixel corner give an empty box; off the corner one pixel
    send_request(draw_req(80, 112, 80, 112, 80, 112, 32'h0bad_cafe, 1'b0));
    send_request(draw_req(84, 116, 84, 116, 84, 116, 32'h0000_0001, 1'b0));
    // vertices on and past the right and bottom screen borders
    send_request(draw_req(4000, 4090, 4096, 4096, 4200, 3990, 32'h8000_0000, 1'b1));
    send_request(read_req(3, 3));
    send_request(read_req(5, 7));
    send_request(read_req(10, 5));
    send_request(read_req(255, 255));

    // zero width: nothing drawn, every read off screen
    apply_screen(0, 17);
    send_request(draw_req(40, 36, 132, 300, 330, 70, 32'h5555_aaaa, 1'b1));
    send_request(read_req(0, 0));
    send_request(read_req(3, 3));

    // oversized registers saturate to the framebuffer size
    apply_screen(511, 300);
    send_request(draw_req(3950, 3950, 4300, 3900, 4200, 4300, 32'h7777_3333, 1'b0));
    send_request(read_req(250, 250));
    send_request(read_req(255, 255));

    // narrow screen: new row stride, extremes with the other winding, off-screen reads
    apply_screen(17, 9);
    send_request(draw_req(-32768, -32768, 32767, -32768, -32768, 32767, 32'hc3c3_3c3c, 1'b1));
    send_request(draw_req(32767, 32767, 32767, -32768, -32768, 32767, 32'h0f0f_f0f0, 1'b0));
    send_request(read_req(16, 8));
    send_request(read_req(17, 3));
    send_request(read_req(3, 9));

    // single pixel screen
    apply_screen(1, 1);
    send_request(draw_req(-16, -16, -16, 64, 64, -16, 32'h2468_ace0, 1'b1));
    send_request(read_req(0, 0));
    send_request(read_req(1, 0));

    // random phases over several screen sizes, the first without any idling
    run_random_phase(MAX_WIDTH, MAX_HEIGHT, 1'b1, 24);
    run_random_phase(64, 48, 1'b0, 24);
    run_random_phase($urandom_range(1, 256), $urandom_range(1, 256), 1'b0, 24);
    run_random_phase(200, 37, 1'b0, 24);
    run_random_phase($urandom_range(1, 256), $urandom_range(1, 256), 1'b0, 24);

    settle();
    $display("drew %0d triangles (%0d pixels filled) and read %0d pixels", shadow.draws,
             shadow.pixels, shadow.reads);
    $display("across %0d screen sizes, including zero, one pixel and saturated", screens_tried);
    if (shadow.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog: room for the clearing pass plus every draw walking its box under full stalls
  initial begin
    #16_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
